/* sv/tile_map_collision_query_unit_defines.svh */
// assertion macros for the tile map collision query unit
`ifndef TILE_MAP_COLLISION_QUERY_UNIT_DEFINES_SVH
`define TILE_MAP_COLLISION_QUERY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TMC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define TMC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TMC_ASSERT_IMP(label, clk, rst, a, c)
`define TMC_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* sv/tmcq_pkg.sv */
package tmcq_pkg;
  localparam int unsigned MapCellsDefault = 4096;
  localparam int unsigned CoordW = 20;
  localparam int unsigned SumW = 22;
  localparam int unsigned QuotW = 18;
  localparam int unsigned CellW = 16;
  localparam int unsigned SizeW = 19;
  localparam int unsigned TileW = 9;
  localparam int unsigned DimW = 7;

  typedef enum logic [1:0] {
    KIND_BOX   = 2'd0,
    KIND_POINT = 2'd1,
    KIND_READ  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_TILE_W = 2'd0,
    REG_TILE_H = 2'd1,
    REG_COLS   = 2'd2,
    REG_ROWS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic [SumW-1:0] dividend;
    logic [TileW-1:0] tile;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [QuotW:0] quot;
  } div_rsp_t;
endpackage

/* sv/tmcq_div.sv */
// signed by unsigned divide, truncating toward zero, one quotient bit per cycle
module tmcq_div (
  input  logic clk,
  input  logic rst,
  input  tmcq_pkg::div_req_t req,
  output tmcq_pkg::div_rsp_t rsp
);
  localparam int unsigned NW = tmcq_pkg::SumW;
  localparam int unsigned DW = tmcq_pkg::TileW + 4;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0] mag;
  logic [NW-1:0] quo;
  logic [DW:0] rem;
  logic [DW-1:0] den;
  logic neg;
  logic [CntW-1:0] cnt;
  logic busy;
  logic done;
  logic [DW:0] trial;
  logic [DW:0] shifted;
  logic [NW-1:0] qmag;

  assign shifted = {rem[DW-1:0], mag[NW-1]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntW'(NW);
        neg <= req.dividend[NW-1];
        mag <= req.dividend[NW-1] ? NW'(-req.dividend) : req.dividend;
        den <= {(req.tile == '0) ? tmcq_pkg::TileW'(1) : req.tile, 4'b0000};
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        mag <= {mag[NW-2:0], 1'b0};
        if (!trial[DW]) begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient of 22-bit by at least 16 fits 18 bits
  assign qmag = neg ? NW'(-quo) : quo;
  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = qmag[tmcq_pkg::QuotW:0];
endmodule

/* sv/tmcq_mem.sv */
// tile cell store, one port, registered read
module tmcq_mem #(
  parameter int unsigned MAP_CELLS = tmcq_pkg::MapCellsDefault
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(MAP_CELLS)-1:0] addr,
  input  logic [tmcq_pkg::CellW-1:0] wdata,
  output logic [tmcq_pkg::CellW-1:0] rdata
);
  logic [tmcq_pkg::CellW-1:0] cells [MAP_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[addr] <= wdata;
    end
    rdata <= cells[addr];
  end
endmodule

/* sv/tile_map_collision_query_unit.sv */
// channel | signals                                          | accepted when
// in      | in_valid in_ready kind box_* move_* cell_*       | in_valid && in_ready
// out     | out_valid out_ready hit read_value out_of_bounds | out_valid && out_ready
// cfg     | cfg_we cfg_index cfg_data                        | cfg_we
//
// one item at a time; a divide loads, forms 22 quotient bits, then flags done
// box query: four divides, clamp, then per scanned row an address state and a scan
// state that steps across the row's tiles, then last and done; a hit ends the scan
// early, an empty box skips it; point query: two divides, then clamp, cell, last
// and done, or clamp and done when off map; read or write: cell, last and done
// reset clears control and restores the registers; cell contents stay undefined
// a finished result waits in the output register while the next item is taken;
// the item after that stalls in the done state until the receiver takes the result
`include "tile_map_collision_query_unit_defines.svh"
module tile_map_collision_query_unit #(
  parameter int unsigned MAP_CELLS = tmcq_pkg::MapCellsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] kind,
  input  logic signed [19:0] box_x,
  input  logic signed [19:0] box_y,
  input  logic [18:0] box_w,
  input  logic [18:0] box_h,
  input  logic signed [19:0] move_x,
  input  logic signed [19:0] move_y,
  input  logic [7:0] cell_col,
  input  logic [7:0] cell_row,
  input  logic signed [15:0] cell_value,
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic signed [15:0] read_value,
  output logic out_of_bounds,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  localparam int unsigned AW = $clog2(MAP_CELLS);
  localparam int unsigned SW = tmcq_pkg::SumW;
  localparam int unsigned QW = tmcq_pkg::QuotW + 1;
  localparam int unsigned IW = 15;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WAIT, S_CLAMP, S_CELL, S_ADDR, S_SCAN, S_LAST, S_DONE
  } state_t;

  state_t state;
  logic [8:0] tile_w, tile_h;
  logic [6:0] cols, rows;

  // captured item
  logic [1:0] k;
  logic signed [SW-1:0] ex0, ey0, ex1, ey1;
  logic [7:0] ccol, crow;
  logic [15:0] cval;
  logic [1:0] dsel;
  logic signed [QW-1:0] q [4];

  // result being built
  logic res_hit;
  logic [15:0] res_value;
  logic res_oob;

  // scan
  logic [6:0] x, y, x0, x1, y1;
  logic [IW-1:0] rowbase;
  logic [IW-1:0] idx;
  logic idx_ok, last_valid, empty;

  tmcq_pkg::div_req_t dreq;
  tmcq_pkg::div_rsp_t drsp;
  logic mwe;
  logic [AW-1:0] maddr;
  logic [15:0] mrdata;

  tmcq_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
  tmcq_mem #(.MAP_CELLS(MAP_CELLS)) u_mem (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(cval), .rdata(mrdata));

  // divide operands: x near, y near, x far, y far
  always_comb begin
    dreq.start = (state == S_DIV);
    case (dsel)
      2'd0: dreq.dividend = ex0;
      2'd1: dreq.dividend = ey0;
      2'd2: dreq.dividend = ex1;
      default: dreq.dividend = ey1;
    endcase
    dreq.tile = dsel[0] ? tile_h : tile_w;
  end

  assign idx = IW'(rowbase) + IW'(x);
  assign idx_ok = (32'(idx) < MAP_CELLS);
  assign maddr = AW'(idx);
  assign mwe = (state == S_CELL) && (k == tmcq_pkg::KIND_WRITE) && idx_ok &&
               (ccol < 8'(cols)) && (crow < 8'(rows));
  assign in_ready = (state == S_IDLE);

  // clamp the tile range to the map; a negative far edge leaves it empty
  logic signed [QW-1:0] cx0, cy0, cx1, cy1, cmax, rmax;
  always_comb begin
    cmax = $signed(QW'(cols) - QW'(1));
    rmax = $signed(QW'(rows) - QW'(1));
    cx0 = (q[0] < 0) ? '0 : q[0];
    cy0 = (q[1] < 0) ? '0 : q[1];
    cx1 = (q[2] > cmax) ? cmax : q[2];
    cy1 = (q[3] > rmax) ? rmax : q[3];
    empty = (cx0 > cx1) || (cy0 > cy1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      last_valid <= 1'b0;
      tile_w <= 9'd16;
      tile_h <= 9'd16;
      cols <= 7'd64;
      rows <= 7'd64;
      dsel <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmcq_pkg::REG_TILE_W: tile_w <= cfg_data;
          tmcq_pkg::REG_TILE_H: tile_h <= cfg_data;
          tmcq_pkg::REG_COLS: cols <= cfg_data[6:0];
          tmcq_pkg::REG_ROWS: rows <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            k <= kind;
            ccol <= cell_col;
            crow <= cell_row;
            cval <= cell_value;
            dsel <= '0;
            res_hit <= 1'b0;
            res_value <= '0;
            res_oob <= 1'b0;
            if (kind == tmcq_pkg::KIND_BOX) begin
              ex0 <= SW'(box_x) - SW'(move_x);
              ey0 <= SW'(box_y) - SW'(move_y);
              ex1 <= SW'(box_x) + SW'({1'b0, box_w}) - SW'(move_x);
              ey1 <= SW'(box_y) + SW'({1'b0, box_h}) - SW'(move_y);
              state <= S_DIV;
            end else if (kind == tmcq_pkg::KIND_POINT) begin
              ex0 <= SW'(box_x);
              ey0 <= SW'(box_y);
              state <= S_DIV;
            end else begin
              rowbase <= IW'(cell_row) * IW'(cols);
              x <= 7'(cell_col);
              state <= S_CELL;
            end
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (drsp.done) begin
            q[dsel] <= drsp.quot;
            dsel <= dsel + 2'd1;
            if ((k == tmcq_pkg::KIND_POINT && dsel == 2'd1) || dsel == 2'd3) begin
              state <= S_CLAMP;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_CLAMP: begin
          if (k == tmcq_pkg::KIND_POINT) begin
            if (q[0] < 0 || q[1] < 0 || q[0] >= QW'(cols) || q[1] >= QW'(rows)) begin
              res_oob <= 1'b1;
              state <= S_DONE;
            end else begin
              x <= q[0][6:0];
              rowbase <= IW'(q[1][6:0]) * IW'(cols);
              ccol <= 8'(q[0][6:0]);
              crow <= 8'(q[1][6:0]);
              state <= S_CELL;
            end
          end else begin
            x0 <= cx0[6:0];
            x <= cx0[6:0];
            x1 <= cx1[6:0];
            y <= cy0[6:0];
            y1 <= cy1[6:0];
            last_valid <= 1'b0;
            state <= empty ? S_DONE : S_ADDR;
          end
        end
        S_ADDR: begin
          // last tile of the previous row arrives here
          if (last_valid && !mrdata[15]) begin
            res_hit <= 1'b1;
            state <= S_DONE;
          end else begin
            rowbase <= IW'(y) * IW'(cols);
            state <= S_SCAN;
          end
          last_valid <= 1'b0;
        end
        S_SCAN: begin
          // memory read issued at idx; its data is checked in the following cycle
          last_valid <= idx_ok;
          if (last_valid && !mrdata[15]) begin
            res_hit <= 1'b1;
            state <= S_DONE;
          end else if (x == x1) begin
            if (y == y1) begin
              state <= S_LAST;
            end else begin
              x <= x0;
              y <= y + 7'd1;
              state <= S_ADDR;
            end
          end else begin
            x <= x + 7'd1;
          end
        end
        S_LAST: begin
          // cell read, point lookup or final scanned tile: data arrives here
          if (k == tmcq_pkg::KIND_POINT) begin
            if (!res_oob) res_hit <= !mrdata[15];
          end else if (k == tmcq_pkg::KIND_READ) begin
            if (!res_oob) res_value <= mrdata;
          end else if (last_valid && !mrdata[15]) begin
            res_hit <= 1'b1;
          end
          last_valid <= 1'b0;
          state <= S_DONE;
        end
        S_CELL: begin
          if (!idx_ok || ccol >= 8'(cols) || crow >= 8'(rows)) begin
            res_oob <= 1'b1;
            k <= tmcq_pkg::KIND_WRITE;
          end
          last_valid <= 1'b0;
          state <= S_LAST;
        end
        S_DONE: begin
          // hold here while the previous result still waits
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            hit <= res_hit;
            read_value <= res_value;
            out_of_bounds <= res_oob;
            state <= S_IDLE;
          end
          last_valid <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMC_ASSERT_IMP(a_busy_no_ready, clk, rst, state != S_IDLE, !in_ready)
  `TMC_ASSERT_IMP(a_oob_no_hit, clk, rst, out_valid, !(hit && out_of_bounds))
  `TMC_ASSERT_NEXT(a_done_valid, clk, rst, state == S_DONE, out_valid)
  `TMC_ASSERT_IMP(a_div_idle, clk, rst, state == S_DIV, !drsp.busy)
endmodule
